// File: rtl/ret_pkg.sv
// ----------------------------------------------------------------------------
// ret_pkg
// Shared types and constants for the Romberg extrapolation table unit.
// ----------------------------------------------------------------------------
package ret_pkg;

    localparam int VALUE_W    = 48;   // signed Q8.40
    localparam int LEVEL_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int RET_LEVELS = 8;
    localparam int FOLD_W     = VALUE_W + 1;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_SAT     = 2'd1,
        STATUS_IGNORED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_SUB,
        CELL_ABS,
        CELL_FOLD,
        CELL_FIN
    } cell_state_t;

    // Travels down the chain of cells, one entry of the row at a time.
    typedef struct packed {
        logic               valid;
        logic [LEVEL_W-1:0] row;
        logic [VALUE_W-1:0] value;
        logic               sat;
    } token_t;

endpackage

// File: rtl/ret_cell.sv
// ----------------------------------------------------------------------------
// ret_cell
// One column of the Romberg table. Holds the previous row's entry K-1 and
// turns entry K-1 of the new row into entry K:
//   a + round((a - b) / (4^K - 1)), saturated to 48 bits.
// The division by 2^(2K)-1 folds the dividend one 2K-bit digit per cycle.
// ----------------------------------------------------------------------------
module ret_cell #(
    parameter int K = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ret_pkg::token_t tok_in,
    output ret_pkg::token_t tok_out
);

    localparam int SH = 2 * K;
    localparam logic [ret_pkg::FOLD_W-1:0] DIVISOR =
        (ret_pkg::FOLD_W'(1) << SH) - ret_pkg::FOLD_W'(1);
    localparam logic [ret_pkg::FOLD_W-1:0] HALF =
        (ret_pkg::FOLD_W'(1) << (SH - 1)) - ret_pkg::FOLD_W'(1);
    localparam logic [ret_pkg::LEVEL_W-1:0] COL      = ret_pkg::LEVEL_W'(K);
    localparam logic [ret_pkg::LEVEL_W-1:0] COL_PREV = ret_pkg::LEVEL_W'(K - 1);

    ret_pkg::cell_state_t state_reg, state_next;
    ret_pkg::token_t      tok_reg, tok_next;

    logic [ret_pkg::VALUE_W-1:0] stored_reg, stored_next;   // previous row, entry K-1
    logic [ret_pkg::VALUE_W-1:0] a_reg, a_next;
    logic [ret_pkg::FOLD_W-1:0]  d_reg, d_next;
    logic [ret_pkg::FOLD_W-1:0]  x_reg, x_next;
    logic [ret_pkg::VALUE_W-1:0] q_reg, q_next;
    logic [ret_pkg::LEVEL_W-1:0] row_reg, row_next;
    logic                        sat_reg, sat_next;

    logic [ret_pkg::FOLD_W-1:0]  hi;
    logic [ret_pkg::FOLD_W-1:0]  fold_sum;
    logic [ret_pkg::FOLD_W:0]    s;
    logic                        ovf_hi, ovf_lo;

    assign hi       = x_reg >> SH;
    assign fold_sum = hi + (x_reg & DIVISOR);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ret_pkg::CELL_IDLE:
            begin
                if (tok_in.valid && (tok_in.row >= COL))
                    state_next = ret_pkg::CELL_SUB;
            end
            ret_pkg::CELL_SUB:  state_next = ret_pkg::CELL_ABS;
            ret_pkg::CELL_ABS:  state_next = ret_pkg::CELL_FOLD;
            ret_pkg::CELL_FOLD:
            begin
                if (hi == '0)
                    state_next = ret_pkg::CELL_FIN;
            end
            ret_pkg::CELL_FIN:  state_next = ret_pkg::CELL_IDLE;
            default:            state_next = ret_pkg::CELL_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        stored_next    = stored_reg;
        a_next         = a_reg;
        d_next         = d_reg;
        x_next         = x_reg;
        q_next         = q_reg;
        row_next       = row_reg;
        sat_next       = sat_reg;
        tok_next       = tok_reg;
        tok_next.valid = 1'b0;

        s = d_reg[ret_pkg::FOLD_W-1]
            ? {{2{a_reg[ret_pkg::VALUE_W-1]}}, a_reg} - {2'b00, q_reg}
            : {{2{a_reg[ret_pkg::VALUE_W-1]}}, a_reg} + {2'b00, q_reg};
        ovf_hi = !s[ret_pkg::FOLD_W] && (s[ret_pkg::FOLD_W-1:ret_pkg::VALUE_W-1] != 2'b00);
        ovf_lo =  s[ret_pkg::FOLD_W] && (s[ret_pkg::FOLD_W-1:ret_pkg::VALUE_W-1] != 2'b11);

        unique case (state_reg)
            ret_pkg::CELL_IDLE:
            begin
                if (tok_in.valid)
                begin
                    if (tok_in.row >= COL)
                    begin
                        a_next   = tok_in.value;
                        row_next = tok_in.row;
                        sat_next = tok_in.sat;
                    end
                    else
                    begin
                        // row ends left of this column: pass it on, and keep
                        // its last entry when it lands on our slot
                        tok_next = tok_in;
                        if (tok_in.row == COL_PREV)
                            stored_next = tok_in.value;
                    end
                end
            end
            ret_pkg::CELL_SUB:
            begin
                d_next = {a_reg[ret_pkg::VALUE_W-1], a_reg}
                       - {stored_reg[ret_pkg::VALUE_W-1], stored_reg};
            end
            ret_pkg::CELL_ABS:
            begin
                // |d| + (divisor-1)/2 for round to nearest
                x_next      = d_reg[ret_pkg::FOLD_W-1] ? HALF - d_reg : HALF + d_reg;
                q_next      = '0;
                stored_next = a_reg;
            end
            ret_pkg::CELL_FOLD:
            begin
                // x = h*2^n + l = h*(2^n-1) + (h + l)
                if (hi != '0)
                begin
                    q_next = q_reg + hi[ret_pkg::VALUE_W-1:0];
                    x_next = fold_sum;
                end
                else if (x_reg == DIVISOR)
                begin
                    q_next = q_reg + ret_pkg::VALUE_W'(1);
                end
            end
            ret_pkg::CELL_FIN:
            begin
                tok_next.valid = 1'b1;
                tok_next.row   = row_reg;
                tok_next.sat   = sat_reg | ovf_hi | ovf_lo;
                if (ovf_hi)
                    tok_next.value = ret_pkg::VALUE_MAX;
                else if (ovf_lo)
                    tok_next.value = ret_pkg::VALUE_MIN;
                else
                    tok_next.value = s[ret_pkg::VALUE_W-1:0];
            end
            default:
            begin
                tok_next.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ret_pkg::CELL_IDLE;
            tok_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stored_reg <= stored_next;
        a_reg      <= a_next;
        d_reg      <= d_next;
        x_reg      <= x_next;
        q_reg      <= q_next;
        row_reg    <= row_next;
        sat_reg    <= sat_next;
    end

    assign tok_out = tok_reg;

endmodule

// File: rtl/romberg_extrapolation_table_unit.sv
// Path: an accepted item goes through the input token register and every column cell;
//   cells up to its row run SUB, ABS, the fold loop and FIN, later cells pass it on.
//   Small differences fold fewer times. An ignored item skips the column cells.
// Throughput: one item at a time; the next item is taken once the result has moved
//   to the output register. The fold loop in each column cell sets how long that takes.
// Reset: asynchronous, active low; clears level, table state and valids. The stored
//   row is undefined until written; no clearing pass.
// ----------------------------------------------------------------------------
// romberg_extrapolation_table_unit
// Builds one Romberg table row per estimate through a chain of column cells until the
// table is full, and returns the row index, the base entry, the diagonal entry and a status.
// ----------------------------------------------------------------------------
module romberg_extrapolation_table_unit #(
    parameter int LEVELS = ret_pkg::RET_LEVELS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                restart,
    input  logic signed [ret_pkg::VALUE_W-1:0]  estimate,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic        [ret_pkg::LEVEL_W-1:0]  level,
    output logic signed [ret_pkg::VALUE_W-1:0]  base_value,
    output logic signed [ret_pkg::VALUE_W-1:0]  diagonal_value,
    output logic        [ret_pkg::STATUS_W-1:0] status
);

    localparam logic [ret_pkg::LEVEL_W-1:0] LEVEL_MAX = ret_pkg::LEVEL_W'(LEVELS);

    logic                        busy_reg, busy_next;
    logic [ret_pkg::LEVEL_W-1:0] cur_level_reg, cur_level_next;
    logic                        started_reg, started_next;
    ret_pkg::token_t             tok0_reg, tok0_next;
    logic [ret_pkg::VALUE_W-1:0] base_reg, base_next;

    logic                        hold_valid_reg, hold_valid_next;
    logic [ret_pkg::LEVEL_W-1:0] hold_level_reg, hold_level_next;
    logic [ret_pkg::VALUE_W-1:0] hold_base_reg, hold_base_next;
    logic [ret_pkg::VALUE_W-1:0] hold_diag_reg, hold_diag_next;
    ret_pkg::status_t            hold_status_reg, hold_status_next;

    logic                        out_valid_reg, out_valid_next;
    logic [ret_pkg::LEVEL_W-1:0] out_level_reg, out_level_next;
    logic [ret_pkg::VALUE_W-1:0] out_base_reg, out_base_next;
    logic [ret_pkg::VALUE_W-1:0] out_diag_reg, out_diag_next;
    ret_pkg::status_t            out_status_reg, out_status_next;

    ret_pkg::token_t             chain [0:LEVELS];

    logic                        accept;
    logic                        new_table;
    logic                        table_full;
    logic [ret_pkg::LEVEL_W-1:0] row_sel;

    assign in_ready   = !busy_reg;
    assign accept     = in_valid && in_ready;
    assign new_table  = restart || !started_reg;
    assign table_full = !new_table && (cur_level_reg >= LEVEL_MAX);
    assign row_sel    = new_table ? '0 : cur_level_reg + ret_pkg::LEVEL_W'(1);

    assign chain[0] = tok0_reg;

    genvar k;
    generate
        for (k = 1; k <= LEVELS; k++)
        begin : g_cell
            ret_cell #(
                .K (k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (chain[k-1]),
                .tok_out (chain[k])
            );
        end
    endgenerate

    always_comb
    begin
        busy_next        = busy_reg;
        cur_level_next   = cur_level_reg;
        started_next     = started_reg;
        tok0_next        = tok0_reg;
        tok0_next.valid  = 1'b0;
        base_next        = base_reg;
        hold_valid_next  = hold_valid_reg;
        hold_level_next  = hold_level_reg;
        hold_base_next   = hold_base_reg;
        hold_diag_next   = hold_diag_reg;
        hold_status_next = hold_status_reg;
        out_valid_next   = out_valid_reg;
        out_level_next   = out_level_reg;
        out_base_next    = out_base_reg;
        out_diag_next    = out_diag_reg;
        out_status_next  = out_status_reg;

        // output register drains first; the held result moves up behind it
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (hold_valid_reg && (!out_valid_reg || out_ready))
        begin
            out_valid_next  = 1'b1;
            out_level_next  = hold_level_reg;
            out_base_next   = hold_base_reg;
            out_diag_next   = hold_diag_reg;
            out_status_next = hold_status_reg;
            hold_valid_next = 1'b0;
            busy_next       = 1'b0;
        end

        if (accept)
        begin
            busy_next = 1'b1;
            base_next = estimate;
            if (table_full)
            begin
                hold_valid_next  = 1'b1;
                hold_level_next  = LEVEL_MAX;
                hold_base_next   = '0;
                hold_diag_next   = '0;
                hold_status_next = ret_pkg::STATUS_IGNORED;
            end
            else
            begin
                tok0_next.valid = 1'b1;
                tok0_next.row   = row_sel;
                tok0_next.value = estimate;
                tok0_next.sat   = 1'b0;
                cur_level_next  = row_sel;
                started_next    = 1'b1;
            end
        end

        if (chain[LEVELS].valid)
        begin
            hold_valid_next  = 1'b1;
            hold_level_next  = chain[LEVELS].row;
            hold_base_next   = base_reg;
            hold_diag_next   = chain[LEVELS].value;
            hold_status_next = chain[LEVELS].sat ? ret_pkg::STATUS_SAT : ret_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            cur_level_reg  <= '0;
            started_reg    <= 1'b0;
            tok0_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            cur_level_reg  <= cur_level_next;
            started_reg    <= started_next;
            tok0_reg       <= tok0_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg        <= base_next;
        hold_level_reg  <= hold_level_next;
        hold_base_reg   <= hold_base_next;
        hold_diag_reg   <= hold_diag_next;
        hold_status_reg <= hold_status_next;
        out_level_reg   <= out_level_next;
        out_base_reg    <= out_base_next;
        out_diag_reg    <= out_diag_next;
        out_status_reg  <= out_status_next;
    end

    assign out_valid      = out_valid_reg;
    assign level          = out_level_reg;
    assign base_value     = out_base_reg;
    assign diagonal_value = out_diag_reg;
    assign status         = out_status_reg;

endmodule

// File: rtl/ret_checker.sv
// ----------------------------------------------------------------------------
// ret_checker
// Port-level checks for the Romberg extrapolation table unit.
// ----------------------------------------------------------------------------
module ret_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                restart,
    input logic signed [ret_pkg::VALUE_W-1:0]  estimate,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic        [ret_pkg::LEVEL_W-1:0]  level,
    input logic signed [ret_pkg::VALUE_W-1:0]  base_value,
    input logic signed [ret_pkg::VALUE_W-1:0]  diagonal_value,
    input logic        [ret_pkg::STATUS_W-1:0] status
);

    // one item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while an item is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ret_pkg::STATUS_OK) || (status == ret_pkg::STATUS_SAT)
                      || (status == ret_pkg::STATUS_IGNORED))
        else $error("undefined status code");

    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ret_pkg::STATUS_IGNORED)
        |-> (base_value == '0) && (diagonal_value == '0))
        else $error("ignored item carries nonzero values");

    // first row has no extrapolation: diagonal is the estimate itself
    a_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (level == '0)
        |-> (status == ret_pkg::STATUS_OK) && (diagonal_value == base_value))
        else $error("row zero diagonal differs from base");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready
        |=> out_valid && $stable(level) && $stable(base_value)
            && $stable(diagonal_value) && $stable(status))
        else $error("stalled result changed");

endmodule

bind romberg_extrapolation_table_unit ret_checker u_ret_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Exercises romberg_extrapolation_table_unit through its valid/ready ports.
// A built-in row tracker recomputes each Romberg row in Q8.40, queues the
// expected level, base entry, diagonal entry and status per accepted item,
// and compares every returned result against the oldest entry. Directed
// items cover extremes, saturation, a full table and restarts. Random
// tables follow, with idle bursts on both sides except near the end.
// ----------------------------------------------------------------------------
module testbench;

    localparam int     VALUE_W      = ret_pkg::VALUE_W;
    localparam int     LEVEL_W      = ret_pkg::LEVEL_W;
    localparam int     STATUS_W     = ret_pkg::STATUS_W;
    localparam int     RET_LEVELS   = ret_pkg::RET_LEVELS;
    localparam int     RANDOM_ITEMS = 2000;
    localparam int     CALM_TAIL    = 300;
    localparam int     STALL_LIMIT  = 2000;
    localparam int     DRAIN_CYCLES = 250;
    localparam longint ENTRY_MAX    = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ENTRY_MIN    = -ENTRY_MAX - 1;

    typedef struct {
        logic [LEVEL_W-1:0]        level;
        logic signed [VALUE_W-1:0] base;
        logic signed [VALUE_W-1:0] diag;
        ret_pkg::status_t          status;
    } row_result_t;

    // Tracks the previous Romberg row and the results each item should give.
    class romberg_rows;
        logic signed [VALUE_W-1:0] prior_row [RET_LEVELS+1];
        int unsigned               last_level;
        bit                        started;
        row_result_t               expected_rows [$];
        int                        mismatches;

        // a + (a - b) / (4^k - 1), nearest rounding, then clamp to 48 bits
        function logic signed [VALUE_W-1:0] extrapolate_entry(
            input logic signed [VALUE_W-1:0] a,
            input logic signed [VALUE_W-1:0] b,
            input int                        k,
            inout bit                        sat
        );
            longint          diff;
            longint          sum;
            longint unsigned mag;
            longint unsigned divisor;
            longint unsigned quot;
            diff    = longint'(a) - longint'(b);
            mag     = (diff < 0) ? longint'(-diff) : diff;
            divisor = (64'd1 << (2 * k)) - 64'd1;
            quot    = (mag + (divisor >> 1)) / divisor;
            sum     = (diff < 0) ? longint'(a) - longint'(quot)
                                 : longint'(a) + longint'(quot);
            if (sum > ENTRY_MAX)
            begin
                sat = 1'b1;
                return VALUE_W'(ENTRY_MAX);
            end
            if (sum < ENTRY_MIN)
            begin
                sat = 1'b1;
                return VALUE_W'(ENTRY_MIN);
            end
            return VALUE_W'(sum);
        endfunction

        function void take_estimate(bit restart_bit, logic signed [VALUE_W-1:0] est);
            row_result_t               res;
            logic signed [VALUE_W-1:0] row [RET_LEVELS+1];
            int unsigned               w;
            bit                        sat;
            if (restart_bit || !started)
                w = 0;
            else if (last_level >= RET_LEVELS)
            begin
                // table full: item dropped, state untouched
                res.level  = LEVEL_W'(RET_LEVELS);
                res.base   = '0;
                res.diag   = '0;
                res.status = ret_pkg::STATUS_IGNORED;
                expected_rows.push_back(res);
                return;
            end
            else
                w = last_level + 1;
            sat    = 1'b0;
            row[0] = est;
            for (int k = 1; k <= w; k++)
                row[k] = extrapolate_entry(row[k-1], prior_row[k-1], k, sat);
            for (int k = 0; k <= w; k++)
                prior_row[k] = row[k];
            last_level = w;
            started    = 1'b1;
            res.level  = LEVEL_W'(w);
            res.base   = row[0];
            res.diag   = row[w];
            res.status = sat ? ret_pkg::STATUS_SAT : ret_pkg::STATUS_OK;
            expected_rows.push_back(res);
        endfunction

        function void check_row(
            logic [LEVEL_W-1:0]        got_level,
            logic signed [VALUE_W-1:0] got_base,
            logic signed [VALUE_W-1:0] got_diag,
            logic [STATUS_W-1:0]       got_status
        );
            row_result_t exp_row;
            if (expected_rows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result with nothing pending: ",
                              "level %0d base %h diag %h status %0d"},
                             $realtime, got_level, got_base, got_diag, got_status);
                return;
            end
            exp_row = expected_rows.pop_front();
            if (got_level !== exp_row.level || got_base !== exp_row.base ||
                got_diag !== exp_row.diag || got_status !== exp_row.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: mismatch: expected level %0d base %h diag %h ",
                              "status %0d, got level %0d base %h diag %h status %0d"},
                             $realtime, exp_row.level, exp_row.base, exp_row.diag,
                             exp_row.status, got_level, got_base, got_diag, got_status);
            end
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction
    endclass

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic                        restart;
    logic signed [VALUE_W-1:0]   estimate;
    logic                        out_valid;
    logic                        out_ready;
    logic [LEVEL_W-1:0]          level;
    logic signed [VALUE_W-1:0]   base_value;
    logic signed [VALUE_W-1:0]   diagonal_value;
    logic [STATUS_W-1:0]         status;

    romberg_rows rows = new;
    bit          idle_on;

    romberg_extrapolation_table_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .restart        (restart),
        .estimate       (estimate),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .level          (level),
        .base_value     (base_value),
        .diagonal_value (diagonal_value),
        .status         (status)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic signed [VALUE_W-1:0] rand_value();
        return {16'($urandom()), 32'($urandom())};
    endfunction

    // style 0/1: converging estimates, 2: raw random, 3: extremes, sometimes random
    function automatic logic signed [VALUE_W-1:0] pick_estimate(
        int style, longint truth, longint spread, int w
    );
        case (style)
            0, 1: return VALUE_W'(truth + (spread >>> (2 * w)));
            2:    return rand_value();
            default:
                case ($urandom_range(0, 5))
                    0: return VALUE_W'(ENTRY_MAX);
                    1: return VALUE_W'(ENTRY_MIN);
                    2: return '0;
                    3: return '1;
                    4: return VALUE_W'(1);
                    default: return rand_value();
                endcase
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(bit restart_bit, logic signed [VALUE_W-1:0] est);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= restart_bit;
        estimate <= est;
        do
            @(posedge clk);
        while (!in_ready);
        rows.take_estimate(restart_bit, est);
        @(negedge clk);
    endtask

    // Receiver back-pressure
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            rows.check_row(level, base_value, diagonal_value, status);
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[romberg_extrapolation_table_unit] ERROR");
        $finish;
    end

    initial
    begin
        int     sent;
        int     rows_in_table;
        int     overflow;
        int     style;
        bit     restart_bit;
        longint truth;
        longint spread;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        restart  = 1'b0;
        estimate = '0;
        idle_on  = 1'b1;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First item after reset without restart still opens level zero
        send_item(1'b0, VALUE_W'(ENTRY_MAX));
        // Max then min drives level one into saturation
        send_item(1'b0, VALUE_W'(ENTRY_MIN));
        send_item(1'b0, '0);
        send_item(1'b0, '1);
        send_item(1'b0, VALUE_W'(1));
        send_item(1'b0, VALUE_W'(ENTRY_MAX));
        send_item(1'b0, VALUE_W'(ENTRY_MIN));
        send_item(1'b0, 48'sh0123_4567_89AB);
        send_item(1'b0, 48'sh5555_AAAA_5555);
        // Table full: these are dropped
        send_item(1'b0, VALUE_W'(5));
        send_item(1'b0, VALUE_W'(ENTRY_MAX));
        // Restart wins over a full table; then a well-behaved table
        send_item(1'b1, 48'sh0202_0000_0000);
        for (int w = 1; w <= RET_LEVELS; w++)
            send_item(1'b0, VALUE_W'(64'sh0200_0000_0000
                                     + (64'sh0010_0000_0000 >>> (2 * w))));
        send_item(1'b1, '1);
        send_item(1'b0, 48'sh7FFF_0000_0000);
        send_item(1'b1, VALUE_W'(ENTRY_MIN));
        send_item(1'b0, VALUE_W'(ENTRY_MAX));

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            rows_in_table = $urandom_range(1, RET_LEVELS + 1);
            overflow      = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
            style         = $urandom_range(0, 3);
            truth         = longint'(rand_value()) >>> 3;
            spread        = longint'(rand_value()) >>> $urandom_range(3, 12);
            idle_on       = (sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 4) != 0);
            for (int w = 0; w < rows_in_table + overflow; w++)
            begin
                // mostly clean tables; a few continue the old one or restart midway
                restart_bit = (w == 0) ? ($urandom_range(0, 7) != 0)
                                       : ($urandom_range(0, 29) == 0);
                send_item(restart_bit, pick_estimate(style, truth, spread, w));
                if (w < rows_in_table)
                    sent++;
            end
        end
        in_valid <= 1'b0;

        while (rows.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (rows.mismatches == 0)
            $display("[romberg_extrapolation_table_unit] OK");
        else
            $display("[romberg_extrapolation_table_unit] ERROR");
        $finish;
    end

endmodule
